// ===== sv/tdpt_pkg.sv =====
// Shared types and constants of the trial-division prime tester.
// No dependencies; imported by tdpt_rem, trial_division_prime_tester_top and the testbench.

package tdpt_pkg;

	// Default width of the numbers that the block works on.
	localparam int WIDTH_DEF = 32;

	// Fixed width of the value and result_value ports.
	localparam int VALUE_W = 32;

	// Item kinds.
	localparam logic KIND_TEST = 1'b0;
	localparam logic KIND_NEXT = 1'b1;

	// Status of the shared remainder unit.
	typedef struct packed {
		logic done;
		logic zero;
	} rem_rsp_t;

endpackage

// ===== sv/tdpt_rem.sv =====
// Shared iterative remainder unit: one restoring step per cycle.
// Depends on tdpt_pkg for the status struct.

module tdpt_rem #(
	parameter int WIDTH = tdpt_pkg::WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [WIDTH-1:0]     dividend,
	input  logic [WIDTH-1:0]     divisor,
	output tdpt_pkg::rem_rsp_t   rsp
);
	import tdpt_pkg::*;

	localparam int CNT_W = $clog2(WIDTH + 1);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] dvd_q;
	logic [WIDTH-1:0] dsr_q;
	logic [WIDTH:0]   shifted;
	logic [WIDTH:0]   diff;

	// The partial remainder stays below twice the divisor, so the top bit
	// of the difference is a clean borrow flag.
	assign shifted = {rem_q, dvd_q[WIDTH-1]};
	assign diff    = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(WIDTH);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
		end else if (run_q) begin
			dvd_q <= {dvd_q[WIDTH-2:0], 1'b0};
			rem_q <= diff[WIDTH] ? shifted[WIDTH-1:0] : diff[WIDTH-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.zero = (rem_q == '0);

endmodule

// ===== sv/trial_division_prime_tester_top.sv =====
// Trial-division prime tester and next-prime finder on the 6k +/- 1 wheel.
// A test checks the candidate by 3 in the shared divider, then by i and i + 2 per
// wheel step, with at most about sqrt(n) / 6 steps. Next mode repeats that per odd
// candidate. Small and even values are settled without the divider. One item at a time.
// Reset clears the sequencer and the strobe; busy and done come out of reset low.

module trial_division_prime_tester_top #(
	parameter int WIDTH = tdpt_pkg::WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         kind,
	input  logic [tdpt_pkg::VALUE_W-1:0] value,
	output logic                         done,
	output logic [tdpt_pkg::VALUE_W-1:0] result_value,
	output logic                         is_prime,
	output logic                         overflow
);
	import tdpt_pkg::*;

	localparam int SQ_W = WIDTH + 2;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CLASS = 3'd1;
	localparam logic [2:0] S_W3    = 3'd2;
	localparam logic [2:0] S_LOOP  = 3'd3;
	localparam logic [2:0] S_WI    = 3'd4;
	localparam logic [2:0] S_WI2   = 3'd5;

	localparam logic [WIDTH-1:0] LIMIT   = {WIDTH{1'b1}} - WIDTH'(2);
	localparam logic [WIDTH-1:0] I_FIRST = WIDTH'(5);
	localparam logic [WIDTH-1:0] I_STEP  = WIDTH'(6);
	localparam logic [SQ_W-1:0]  SQ_FIRST  = SQ_W'(25);
	localparam logic [SQ_W-1:0]  DLT_FIRST = SQ_W'(96);
	localparam logic [SQ_W-1:0]  DLT_STEP  = SQ_W'(72);

	logic [2:0]       state_q;
	logic             kind_q;
	logic [WIDTH-1:0] cand_q;
	logic [WIDTH-1:0] i_q;
	logic [SQ_W-1:0]  sq_q;
	logic [SQ_W-1:0]  dlt_q;
	logic             done_q;
	logic [WIDTH-1:0] res_q;
	logic             prime_q;
	logic             ovf_q;

	logic [WIDTH-1:0] n_in;
	logic             sq_over;
	logic             vrd_valid;
	logic             vrd_prime;
	logic             rem_start;
	logic [WIDTH-1:0] rem_dsr;
	rem_rsp_t         rem_rsp;

	assign n_in         = WIDTH'(value);
	assign result_value = VALUE_W'(res_q);

	// The loop runs while i * i <= candidate; sq_q tracks i * i by adding
	// the running difference 12i + 36 at each wheel step.
	assign sq_over = (sq_q > {2'b00, cand_q});

	always_comb begin
		vrd_valid = 1'b0;
		vrd_prime = 1'b0;
		case (state_q)
			S_CLASS: begin
				if (cand_q <= WIDTH'(1)) begin
					vrd_valid = 1'b1;
				end else if (cand_q <= WIDTH'(3)) begin
					vrd_valid = 1'b1;
					vrd_prime = 1'b1;
				end else if (!cand_q[0]) begin
					vrd_valid = 1'b1;
				end
			end
			S_W3, S_WI, S_WI2: begin
				vrd_valid = rem_rsp.done && rem_rsp.zero;
			end
			S_LOOP: begin
				vrd_valid = sq_over;
				vrd_prime = 1'b1;
			end
			default: begin
				vrd_valid = 1'b0;
			end
		endcase
	end

	always_comb begin
		rem_start = 1'b0;
		rem_dsr   = i_q;
		case (state_q)
			S_CLASS: begin
				rem_start = !vrd_valid;
				rem_dsr   = WIDTH'(3);
			end
			S_LOOP: begin
				rem_start = !sq_over;
				rem_dsr   = i_q;
			end
			S_WI: begin
				rem_start = rem_rsp.done && !rem_rsp.zero;
				rem_dsr   = i_q + WIDTH'(2);
			end
			default: begin
				rem_start = 1'b0;
			end
		endcase
	end

	tdpt_rem #(
		.WIDTH (WIDTH)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (cand_q),
		.divisor  (rem_dsr),
		.rsp      (rem_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= KIND_TEST;
			cand_q  <= '0;
			i_q     <= '0;
			sq_q    <= '0;
			dlt_q   <= '0;
			done_q  <= 1'b0;
			res_q   <= '0;
			prime_q <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (state_q == S_IDLE) begin
				if (start) begin
					kind_q <= kind;
					if (kind == KIND_NEXT && n_in <= WIDTH'(2)) begin
						done_q  <= 1'b1;
						res_q   <= WIDTH'(2);
						prime_q <= 1'b1;
						ovf_q   <= 1'b0;
					end else begin
						cand_q  <= (kind == KIND_NEXT) ? (n_in | WIDTH'(1)) : n_in;
						state_q <= S_CLASS;
					end
				end
			end else if (vrd_valid) begin
				// A composite in next mode steps to the next odd, or overflows.
				if (kind_q == KIND_TEST || vrd_prime) begin
					done_q  <= 1'b1;
					res_q   <= cand_q;
					prime_q <= vrd_prime;
					ovf_q   <= 1'b0;
					state_q <= S_IDLE;
				end else if (cand_q > LIMIT) begin
					done_q  <= 1'b1;
					res_q   <= '0;
					prime_q <= 1'b0;
					ovf_q   <= 1'b1;
					state_q <= S_IDLE;
				end else begin
					cand_q  <= cand_q + WIDTH'(2);
					state_q <= S_CLASS;
				end
			end else begin
				case (state_q)
					S_CLASS: begin
						state_q <= S_W3;
					end
					S_W3: begin
						if (rem_rsp.done) begin
							i_q     <= I_FIRST;
							sq_q    <= SQ_FIRST;
							dlt_q   <= DLT_FIRST;
							state_q <= S_LOOP;
						end
					end
					S_LOOP: begin
						state_q <= S_WI;
					end
					S_WI: begin
						if (rem_rsp.done) begin
							state_q <= S_WI2;
						end
					end
					S_WI2: begin
						if (rem_rsp.done) begin
							i_q     <= i_q + I_STEP;
							sq_q    <= sq_q + dlt_q;
							dlt_q   <= dlt_q + DLT_STEP;
							state_q <= S_LOOP;
						end
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

	assign busy     = (state_q != S_IDLE);
	assign done     = done_q;
	assign is_prime = prime_q;
	assign overflow = ovf_q;

`ifndef SYNTHESIS
	// A result is only given out once the sequencer is back in idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while the sequencer is still busy");

	// An overflowed search reports no prime and a zero result.
	a_ovf_result: assert property (@(posedge clk) disable iff (!arst_n)
		done && overflow |-> !is_prime && result_value == '0)
		else $error("overflow result carries a prime or a value");

	// The divider only finishes while an item is in progress.
	a_rem_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rem_rsp.done |-> busy)
		else $error("divider finished while the sequencer was idle");

	// Accepting an item that needs trial division makes the block busy.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !(kind == KIND_NEXT && n_in <= WIDTH'(2)) |=> busy)
		else $error("accepted item did not start the sequencer");
`endif

endmodule

// ===== tb/sv/trial_division_prime_tester_top_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for trial_division_prime_tester_top: a directed table,
// then bursts of random test and next-prime items, checked against a local predictor.
// Depends on tdpt_pkg and trial_division_prime_tester_top.

module trial_division_prime_tester_top_tb;

	import tdpt_pkg::*;

	localparam int WIDTH = WIDTH_DEF;
	localparam longint unsigned VALUE_MASK = (WIDTH >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF
		: ((64'd1 << WIDTH) - 64'd1);
	localparam int RANDOM_ITEMS = 80;
	localparam int N_DIRECTED = 24;
	// The slowest item below is the overflowing search from 2^32 - 4, which tests
	// 2^32 - 3 (smallest factor 9241) through every wheel step up to that factor.
	localparam int IDLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 4 * (WIDTH + 3);

	typedef struct packed {
		logic [VALUE_W-1:0] result_value;
		logic               is_prime;
		logic               overflow;
	} prime_result_t;

	typedef struct {
		logic               kind;
		logic [VALUE_W-1:0] value;
		bit                 typed;
		prime_result_t      want;
	} stim_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               kind = KIND_TEST;
	logic [VALUE_W-1:0] value = '0;
	logic               busy;
	logic               done;
	logic [VALUE_W-1:0] result_value;
	logic               is_prime;
	logic               overflow;

	prime_result_t pending_results[$];
	prime_result_t head_result;
	int            error_count = 0;
	int            idle_cycles = 0;
	int            n_tests = 0;
	int            n_searches = 0;
	int            n_prime_results = 0;
	int            n_overflows = 0;

	// Squares of wheel primes sit exactly on the i*i <= n bound of the loop.
	stim_row_t directed_rows [N_DIRECTED] = '{
		'{KIND_TEST, 32'd0,          1'b1, '{32'd0,          1'b0, 1'b0}},
		'{KIND_TEST, 32'd1,          1'b1, '{32'd1,          1'b0, 1'b0}},
		'{KIND_TEST, 32'd2,          1'b1, '{32'd2,          1'b1, 1'b0}},
		'{KIND_TEST, 32'd3,          1'b1, '{32'd3,          1'b1, 1'b0}},
		'{KIND_TEST, 32'd4,          1'b1, '{32'd4,          1'b0, 1'b0}},
		'{KIND_TEST, 32'd5,          1'b0, '{32'd0,          1'b0, 1'b0}},
		'{KIND_TEST, 32'd25,         1'b0, '{32'd0,          1'b0, 1'b0}},
		'{KIND_TEST, 32'd35,         1'b0, '{32'd0,          1'b0, 1'b0}},
		'{KIND_TEST, 32'd49,         1'b0, '{32'd0,          1'b0, 1'b0}},
		'{KIND_TEST, 32'd121,        1'b0, '{32'd0,          1'b0, 1'b0}},
		'{KIND_TEST, 32'd1018081,    1'b0, '{32'd0,          1'b0, 1'b0}},
		'{KIND_TEST, 32'd65521,      1'b0, '{32'd0,          1'b0, 1'b0}},
		'{KIND_TEST, 32'd1000003,    1'b0, '{32'd0,          1'b0, 1'b0}},
		'{KIND_TEST, 32'hFFFF_FFFF,  1'b1, '{32'hFFFF_FFFF,  1'b0, 1'b0}},
		'{KIND_TEST, 32'hFFFF_FFFE,  1'b1, '{32'hFFFF_FFFE,  1'b0, 1'b0}},
		'{KIND_TEST, 32'h8000_0000,  1'b1, '{32'h8000_0000,  1'b0, 1'b0}},
		'{KIND_NEXT, 32'd0,          1'b1, '{32'd2,          1'b1, 1'b0}},
		'{KIND_NEXT, 32'd1,          1'b1, '{32'd2,          1'b1, 1'b0}},
		'{KIND_NEXT, 32'd2,          1'b1, '{32'd2,          1'b1, 1'b0}},
		'{KIND_NEXT, 32'd3,          1'b0, '{32'd0,          1'b0, 1'b0}},
		'{KIND_NEXT, 32'd114,        1'b0, '{32'd0,          1'b0, 1'b0}},
		'{KIND_NEXT, 32'd65520,      1'b0, '{32'd0,          1'b0, 1'b0}},
		'{KIND_NEXT, 32'hFFFF_FFFF,  1'b1, '{32'd0,          1'b0, 1'b1}},
		'{KIND_NEXT, 32'hFFFF_FFFC,  1'b1, '{32'd0,          1'b0, 1'b1}}
	};

	int small_factors [12] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};

	trial_division_prime_tester_top #(
		.WIDTH(WIDTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.value(value),
		.done(done),
		.result_value(result_value),
		.is_prime(is_prime),
		.overflow(overflow)
	);

	always #4 clk = ~clk;

	function automatic bit wheel_is_prime(longint unsigned n);
		longint unsigned i;
		if (n <= 64'd1)
			return 1'b0;
		if (n <= 64'd3)
			return 1'b1;
		if ((n % 64'd2) == 0 || (n % 64'd3) == 0)
			return 1'b0;
		for (i = 64'd5; i <= n / i; i += 64'd6) begin
			if ((n % i) == 0 || (n % (i + 64'd2)) == 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic prime_result_t predict_prime_result(logic k, logic [VALUE_W-1:0] v);
		prime_result_t   r;
		longint unsigned n;
		longint unsigned cand;
		n = longint'(v) & VALUE_MASK;
		r = '0;
		if (k == KIND_TEST) begin
			r.result_value = n[VALUE_W-1:0];
			r.is_prime = wheel_is_prime(n);
		end else if (n <= 64'd2) begin
			r.result_value = 2;
			r.is_prime = 1'b1;
		end else begin
			cand = n | 64'd1;
			forever begin
				if (wheel_is_prime(cand)) begin
					r.result_value = cand[VALUE_W-1:0];
					r.is_prime = 1'b1;
					break;
				end
				if (cand > VALUE_MASK - 64'd2) begin
					r.overflow = 1'b1;
					break;
				end
				cand += 64'd2;
			end
		end
		return r;
	endfunction

	// Holds the item until the block takes it, then books the expected result.
	task automatic issue_item(input logic k, input logic [VALUE_W-1:0] v,
		input prime_result_t want);
		start <= 1'b1;
		kind <= k;
		value <= v;
		do @(posedge clk); while (busy);
		pending_results = {pending_results, want};
		if (k == KIND_NEXT)
			n_searches++;
		else
			n_tests++;
	endtask

	// Only called with a nonzero cycle count so start never gets two updates in a step.
	task automatic pause_sender(input int cycles);
		start <= 1'b0;
		kind <= logic'($urandom_range(0, 1));
		value <= $urandom();
		repeat (cycles) @(posedge clk);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Most items stay small so that each search or test stays short; most large values
	// are built with a small factor so they finish early.
	task automatic pick_random_item(output logic k, output logic [VALUE_W-1:0] v);
		logic [VALUE_W-1:0] r;
		int                 f;
		r = $urandom();
		f = small_factors[$urandom_range(0, 11)];
		case ($urandom_range(0, 19))
			0, 1, 2, 3, 4, 5, 6: begin
				k = KIND_TEST;
				v = $urandom_range(0, 65535);
			end
			7, 8, 9, 10, 11: begin
				k = KIND_NEXT;
				v = $urandom_range(0, 40000);
			end
			18: begin
				k = KIND_TEST;
				v = $urandom_range(65536, 1 << 20);
			end
			19: begin
				k = KIND_NEXT;
				v = $urandom_range(32'hFFFF_FFFE, 32'hFFFF_FFFF);
			end
			default: begin
				k = KIND_TEST;
				v = r - (r % f);
			end
		endcase
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (pending_results.size() == 0) begin
					$error("unexpected result: result_value %0d is_prime %0b overflow %0b",
						result_value, is_prime, overflow);
					error_count++;
				end else begin
					head_result = pending_results.pop_front();
					if (result_value !== head_result.result_value) begin
						$error("result_value: expected %0d, got %0d",
							head_result.result_value, result_value);
						error_count++;
					end
					if (is_prime !== head_result.is_prime) begin
						$error("is_prime: expected %0b, got %0b", head_result.is_prime, is_prime);
						error_count++;
					end
					if (overflow !== head_result.overflow) begin
						$error("overflow: expected %0b, got %0b", head_result.overflow, overflow);
						error_count++;
					end
				end
				if (is_prime === 1'b1)
					n_prime_results++;
				if (overflow === 1'b1)
					n_overflows++;
			end
			if ((start && !busy) || done)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout after %0d cycles with no item or result moving", idle_cycles);
				$display("trial_division_prime_tester_top_tb: errors");
				$finish;
			end
		end
	end

	initial begin
		logic               k;
		logic [VALUE_W-1:0] v;
		int                 issued;
		int                 burst_len;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[idx]) begin
			issue_item(directed_rows[idx].kind, directed_rows[idx].value,
				directed_rows[idx].typed ? directed_rows[idx].want
				: predict_prime_result(directed_rows[idx].kind, directed_rows[idx].value));
			if ($urandom_range(0, 2) == 0)
				pause_sender($urandom_range(1, 5));
		end
		drain_results();

		issued = 0;
		while (issued < RANDOM_ITEMS) begin
			burst_len = $urandom_range(1, 12);
			repeat (burst_len) begin
				pick_random_item(k, v);
				issue_item(k, v, predict_prime_result(k, v));
				issued++;
			end
			case ($urandom_range(0, 7))
				0: drain_results();
				1: pause_sender($urandom_range(30, 200));
				default: pause_sender($urandom_range(1, 12));
			endcase
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Covered %0d primality tests and %0d next-prime searches.",
			n_tests, n_searches);
		$display("Results seen: %0d prime, %0d search overflows.", n_prime_results, n_overflows);
		if (error_count == 0)
			$display("trial_division_prime_tester_top_tb: clean");
		else
			$display("trial_division_prime_tester_top_tb: errors");
		$finish;
	end

endmodule

// ===== trial_division_prime_tester_top.f =====
sv/tdpt_pkg.sv
sv/tdpt_rem.sv
sv/trial_division_prime_tester_top.sv
tb/sv/trial_division_prime_tester_top_tb.sv
